// ----- sv/two_button_press_classifier_macros.svh -----
// ---------------------------------------------------------------------------
// Two-button press classifier assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef TWO_BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define TWO_BUTTON_PRESS_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TBPC_ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tbpc assertion failed");
`define TBPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbpc assertion failed");
`else
`define TBPC_ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define TBPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/tbpc_pkg.sv -----
// ---------------------------------------------------------------------------
// Two-button press classifier package
// Shared widths, register indexes, key codes and lane status type.
// ---------------------------------------------------------------------------
package tbpc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int THR_BITS   = 16;
    localparam int CMP_BITS   = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
    localparam int ADDR_BITS  = 3;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(100);

    // register index, taken from paddr[2]
    localparam logic REG_LONG_TICKS = 1'b0;
    localparam logic REG_HAND_SWAP  = 1'b1;

    typedef enum logic [2:0] {
        KEY_NONE      = 3'd0,
        KEY_SHORT_ONE = 3'd1,
        KEY_SHORT_TWO = 3'd2,
        KEY_LONG_ONE  = 3'd3,
        KEY_LONG_TWO  = 3'd4
    } t_key;

    typedef struct packed {
        logic long_hit;
        logic short_hit;
    } t_lane_hit;

endpackage

// ----- sv/tbpc_lane.sv -----
// ---------------------------------------------------------------------------
// Two-button press classifier button lane
// Hold counter, armed and taken bits of one button; flags long/short hits.
// ---------------------------------------------------------------------------
module tbpc_lane
    import tbpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_down,
    input  logic                i_long_allowed,
    input  logic [THR_BITS-1:0] i_thr,
    input  logic                i_other_zero,
    output logic                o_inc_zero,
    output t_lane_hit           o_hit
);

    logic [COUNT_BITS-1:0] r_cnt,   n_cnt;
    logic                  r_armed, n_armed;
    logic                  r_taken, n_taken;

    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CMP_BITS-1:0]   cnt_cmp;
    logic [CMP_BITS-1:0]   thr_cmp;
    logic                  armed_q;
    logic                  at_long;
    logic                  taken_q;

    always_comb begin
        if (i_down && (r_cnt != '1)) begin
            cnt_inc = r_cnt + COUNT_BITS'(1);
        end else begin
            cnt_inc = r_cnt;
        end
    end

    assign o_inc_zero = (cnt_inc == '0);

    always_comb begin
        armed_q    = r_armed & i_long_allowed;
        cnt_cmp    = CMP_BITS'(cnt_inc);
        thr_cmp    = CMP_BITS'(i_thr);
        at_long    = (cnt_cmp >= thr_cmp);

        o_hit.long_hit  = at_long & i_long_allowed & armed_q & i_other_zero;
        taken_q         = r_taken | o_hit.long_hit;
        o_hit.short_hit = !i_down && !taken_q && !at_long && !o_inc_zero;

        if (i_down) begin
            n_cnt   = cnt_inc;
            n_taken = taken_q;
            n_armed = armed_q;
        end else begin
            n_cnt   = '0;
            n_taken = 1'b0;
            n_armed = o_inc_zero ? 1'b1 : armed_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_armed <= 1'b1;
            r_taken <= 1'b0;
        end else if (i_en) begin
            r_cnt   <= n_cnt;
            r_armed <= n_armed;
            r_taken <= n_taken;
        end
    end

endmodule

// ----- sv/tbpc_merge.sv -----
// ---------------------------------------------------------------------------
// Two-button press classifier merge
// Combines the hits of both lanes into one key code, last event wins.
// ---------------------------------------------------------------------------
module tbpc_merge
    import tbpc_pkg::*;
(
    input  t_lane_hit i_hit_a,
    input  t_lane_hit i_hit_b,
    input  logic      i_swap,
    output t_key      o_key
);

    // release of B, release of A, long B, long A: later events override
    always_comb begin
        priority if (i_hit_b.short_hit) begin
            o_key = i_swap ? KEY_SHORT_TWO : KEY_SHORT_ONE;
        end else if (i_hit_a.short_hit) begin
            o_key = i_swap ? KEY_SHORT_ONE : KEY_SHORT_TWO;
        end else if (i_hit_b.long_hit) begin
            o_key = i_swap ? KEY_LONG_TWO : KEY_LONG_ONE;
        end else if (i_hit_a.long_hit) begin
            o_key = i_swap ? KEY_LONG_ONE : KEY_LONG_TWO;
        end else begin
            o_key = KEY_NONE;
        end
    end

endmodule

// ----- sv/two_button_press_classifier.sv -----
// ---------------------------------------------------------------------------
// Two-button press classifier
// Classifies short and long presses of two buttons, one tick per item.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per timer tick, tdata = {long_allowed,
//   button_b_down, button_a_down} in bits [2:0].
//   Master stream: exactly one item per input item, key code in tdata[2:0]
//   (0 none, 1/2 short key one/two, 3/4 long key one/two).
//   APB port: long_press_ticks at 0x0, hand_swap at 0x4; write only while
//   idle. pready is tied high, reads return the register value.
//   The result is registered in the output register, or in the skid while
//   the output register is full. Throughput: one item per cycle while tready
//   is high; each button lane updates its hold counter and flags per item.
//   A two-entry output stage (output register plus skid) lets the block take
//   an item while a result waits; tready drops only when both are full.
//   Reset (synchronous, active low) clears the counters and taken bits, arms
//   both buttons, empties the output stage and loads register defaults.
// ---------------------------------------------------------------------------
`include "two_button_press_classifier_macros.svh"

module two_button_press_classifier
    import tbpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,  // [0] button_a_down, [1] button_b_down,
                                             // [2] long_allowed, [7:3] zero
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [7:0]           o_m_tdata,  // [2:0] key_code, [7:3] zero
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [THR_BITS-1:0] r_thr;
    logic                r_swap;

    logic      push;
    logic      pop;
    logic      zero_a, zero_b;
    t_lane_hit hit_a, hit_b;
    t_key      key;

    logic r_out_v, r_skid_v;
    t_key r_out_key, r_skid_key;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_swap <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_LONG_TICKS: r_thr  <= pwdata[THR_BITS-1:0];
                REG_HAND_SWAP:  r_swap <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LONG_TICKS: prdata = 32'(r_thr);
            REG_HAND_SWAP:  prdata = {31'd0, r_swap};
            default:        prdata = '0;
        endcase
    end

    // lanes
    assign o_s_tready = !r_skid_v;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = r_out_v && i_m_tready;

    tbpc_lane u_lane_a (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (push),
        .i_down         (i_s_tdata[0]),
        .i_long_allowed (i_s_tdata[2]),
        .i_thr          (r_thr),
        .i_other_zero   (zero_b),
        .o_inc_zero     (zero_a),
        .o_hit          (hit_a)
    );

    tbpc_lane u_lane_b (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (push),
        .i_down         (i_s_tdata[1]),
        .i_long_allowed (i_s_tdata[2]),
        .i_thr          (r_thr),
        .i_other_zero   (zero_a),
        .o_inc_zero     (zero_b),
        .o_hit          (hit_b)
    );

    tbpc_merge u_merge (
        .i_hit_a (hit_a),
        .i_hit_b (hit_b),
        .i_swap  (r_swap),
        .o_key   (key)
    );

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            r_out_key <= r_skid_v ? r_skid_key : key;
        end else if (push) begin
            r_skid_key <= key;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {5'd0, r_out_key};

    `TBPC_ASSERT_HOLDS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_v || r_out_v)
    `TBPC_ASSERT_HOLDS(a_lane_a_excl, i_clk, i_rst_n, !(hit_a.long_hit && hit_a.short_hit))
    `TBPC_ASSERT_HOLDS(a_lane_b_excl, i_clk, i_rst_n, !(hit_b.long_hit && hit_b.short_hit))
    `TBPC_ASSERT_NEXT(a_push_fills_out, i_clk, i_rst_n, push, r_out_v)

endmodule
